@@ sv/spfa_pkg.sv @@
// Shared constants, widths and state codes of the shortest path unit.
`default_nettype none
package spfa_pkg;
   localparam int DEF_MAX_NODES      = 1024;
   localparam int DEF_MAX_EDGE_SLOTS = 8192;
   localparam int DEF_WEIGHT_BITS    = 16;

   localparam int ACTION_BITS = 2;
   localparam int NODE_BITS   = 10;
   localparam int WEIGHT_IN_BITS = 16;
   localparam int DIST_BITS   = 30;
   localparam int COUNT_BITS  = 11;
   localparam int REQ_BITS    = 40;
   localparam int RSP_BITS    = 32;

   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 11'd1024;
   localparam logic [DIST_BITS-1:0]  SENTINEL      = 30'h3f3f3f3f;
   localparam logic [DIST_BITS-1:0]  HALF_SENTINEL = 30'h1f9f9f9f;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_ADD_RA, ST_ADD_WA, ST_ADD_RB, ST_ADD_WB,
      ST_INIT, ST_START, ST_POP, ST_POP_W, ST_NODE, ST_EDGE, ST_EDGE_W,
      ST_RELAX, ST_FINAL, ST_FINAL_W
   } state_type;
endpackage
`default_nettype wire

@@ sv/spfa_shortest_path_unit.sv @@
// Top level: adjacency store, SPFA relaxation sequencer and result register.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  action, node_a, node_b, weight
//  rsp      out        rsp_tvalid/rsp_tready  reachable, distance
//  csr      in         csr_valid/csr_ready    node_count
//
// Clear sweeps the head table; add-edge reads and rewrites the head of node_a
// and then of node_b. A query sets the distance of min(node_count, MAX_NODES)
// nodes, then pops each queued node and scans its edges, then reads node_b;
// the node and edge memory ports set the pace, one access each per cycle.
// After reset a sweep of all MAX_NODES entries clears heads and queue flags;
// no request is taken during it. A stalled result holds only a finishing query.
`default_nettype none
module spfa_shortest_path_unit
   import spfa_pkg::*;
#(
   parameter int MAX_NODES      = DEF_MAX_NODES,
   parameter int MAX_EDGE_SLOTS = DEF_MAX_EDGE_SLOTS,
   parameter int WEIGHT_BITS    = DEF_WEIGHT_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // action[1:0], node_a[11:2], node_b[21:12], weight[37:22], zeros[39:38]
   input  wire logic [REQ_BITS-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // reachable[0], distance[30:1], zero[31]
   output logic      [RSP_BITS-1:0]   rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [COUNT_BITS-1:0] csr_data
);
   localparam int NB  = $clog2(MAX_NODES);
   localparam int EAW = $clog2(MAX_EDGE_SLOTS);
   localparam int EB  = EAW + 1;
   localparam int NW  = DIST_BITS + 1;
   localparam int EW  = NB + EB + WEIGHT_BITS;
   localparam logic [EB-1:0] NULL_LINK = '1;
   localparam logic [NB-1:0] LAST_NODE = NB'(MAX_NODES - 1);

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] node_count_ff, node_count_in;
   logic [NODE_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [NB-1:0] idx_ff, idx_in, rd_ff, rd_in, wr_ff, wr_in, t_ff, t_in, j_ff, j_in;
   logic [NB:0] cnt_ff, cnt_in, lim_ff, lim_in;
   logic [EB-1:0] ecount_ff, ecount_in, e_ff, e_in;
   logic [DIST_BITS-1:0] dist_t_ff, dist_t_in, cand_ff, cand_in;
   logic sweep_all_ff, sweep_all_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS:0] rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic head_we, head_re;
   logic [NB-1:0] head_wa, head_ra;
   logic [EB-1:0] head_wd, head_rd;
   logic node_we, node_re;
   logic [NB-1:0] node_wa, node_ra;
   logic [NW-1:0] node_wd, node_rd;
   logic edge_we, edge_re;
   logic [EAW-1:0] edge_wa, edge_ra;
   logic [EW-1:0] edge_wd, edge_rd;
   logic q_we, q_re;
   logic [NB-1:0] q_wa, q_ra, q_wd, q_rd;

   logic [ACTION_BITS-1:0] req_action;
   logic [NODE_BITS-1:0] req_a, req_b;
   logic [WEIGHT_IN_BITS-1:0] req_w;
   logic a_ok, b_ok, req_a_ok, req_b_ok, room;
   logic [NB-1:0] a_idx, b_idx, rd_next, wr_next;
   logic [NB:0] lim_calc;
   logic [DIST_BITS+3:0] sum;
   logic [DIST_BITS-1:0] cand_calc, d_final;
   logic [NB-1:0] ej;
   logic [EB-1:0] enext;
   logic [WEIGHT_BITS-1:0] ew;
   logic push;

   assign req_action = req_tdata[1:0];
   assign req_a = req_tdata[11:2];
   assign req_b = req_tdata[21:12];
   assign req_w = req_tdata[37:22];
   assign req_a_ok = 32'(req_a) < MAX_NODES;
   assign req_b_ok = 32'(req_b) < MAX_NODES;
   assign a_ok = 32'(a_ff) < MAX_NODES;
   assign b_ok = 32'(b_ff) < MAX_NODES;
   assign a_idx = NB'(a_ff);
   assign b_idx = NB'(b_ff);
   assign room = ((EB+1)'(ecount_ff) + (EB+1)'(2)) <= (EB+1)'(MAX_EDGE_SLOTS);
   assign lim_calc = (32'(node_count_ff) > MAX_NODES) ? (NB+1)'(MAX_NODES)
                                                      : (NB+1)'(node_count_ff);
   assign rd_next = (rd_ff == LAST_NODE) ? '0 : rd_ff + 1'b1;
   assign wr_next = (wr_ff == LAST_NODE) ? '0 : wr_ff + 1'b1;
   assign {ej, enext, ew} = edge_rd;
   assign sum = (DIST_BITS+4)'(dist_t_ff) + (DIST_BITS+4)'(ew);
   assign cand_calc = (sum > (DIST_BITS+4)'(SENTINEL)) ? SENTINEL : sum[DIST_BITS-1:0];
   assign d_final = b_ok ? node_rd[DIST_BITS-1:0] : SENTINEL;
   assign push = !node_rd[DIST_BITS] && (32'(cnt_ff) < MAX_NODES);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_data_ff[DIST_BITS-1:0], rsp_data_ff[DIST_BITS]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP:   if (idx_ff == LAST_NODE) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_action)
                  ACT_CLEAR: state_in = ST_SWEEP;
                  ACT_ADD:   if (req_a_ok && req_b_ok && room) state_in = ST_ADD_RA;
                  ACT_QUERY: state_in = (lim_calc == '0) ? ST_START : ST_INIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RA:  state_in = ST_ADD_WA;
         ST_ADD_WA:  state_in = ST_ADD_RB;
         ST_ADD_RB:  state_in = ST_ADD_WB;
         ST_ADD_WB:  state_in = ST_IDLE;
         ST_INIT:    if ({1'b0, idx_ff} + 1'b1 == lim_ff) state_in = ST_START;
         ST_START:   state_in = a_ok ? ST_POP : ST_FINAL;
         ST_POP:     state_in = (cnt_ff == '0) ? ST_FINAL : ST_POP_W;
         ST_POP_W:   state_in = ST_NODE;
         ST_NODE:    state_in = ST_EDGE;
         ST_EDGE:    state_in = (e_ff == NULL_LINK || e_ff >= ecount_ff) ? ST_POP : ST_EDGE_W;
         ST_EDGE_W:  state_in = ST_RELAX;
         ST_RELAX:   state_in = ST_EDGE;
         ST_FINAL:   state_in = ST_FINAL_W;
         ST_FINAL_W: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      node_count_in = csr_valid ? csr_data : node_count_ff;
      a_in = a_ff; b_in = b_ff; w_in = w_ff;
      idx_in = idx_ff; rd_in = rd_ff; wr_in = wr_ff; cnt_in = cnt_ff; lim_in = lim_ff;
      t_in = t_ff; j_in = j_ff; ecount_in = ecount_ff; e_in = e_ff;
      dist_t_in = dist_t_ff; cand_in = cand_ff; sweep_all_in = sweep_all_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      head_we = 1'b0; head_wa = idx_ff; head_wd = NULL_LINK;
      head_re = 1'b0; head_ra = a_idx;
      node_we = 1'b0; node_wa = idx_ff; node_wd = {1'b0, SENTINEL};
      node_re = 1'b0; node_ra = t_ff;
      edge_we = 1'b0; edge_wa = ecount_ff[EAW-1:0]; edge_wd = {b_idx, head_rd, w_ff};
      edge_re = 1'b0; edge_ra = e_ff[EAW-1:0];
      q_we = 1'b0; q_wa = wr_ff; q_wd = j_ff;
      q_re = 1'b0; q_ra = rd_ff;
      case (state_ff)
         ST_SWEEP: begin
            head_we = 1'b1;
            node_we = sweep_all_ff;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_NODE) begin
               idx_in = '0;
               sweep_all_in = 1'b0;
            end
         end
         ST_IDLE: begin
            idx_in = '0;
            lim_in = lim_calc;
            if (req_tvalid) begin
               a_in = req_a; b_in = req_b; w_in = WEIGHT_BITS'(req_w);
               if (req_action == ACT_CLEAR) ecount_in = '0;
            end
         end
         ST_ADD_RA: head_re = 1'b1;
         ST_ADD_WA: begin
            edge_we = 1'b1;
            head_we = 1'b1; head_wa = a_idx; head_wd = ecount_ff;
            ecount_in = ecount_ff + 1'b1;
         end
         ST_ADD_RB: begin
            head_re = 1'b1; head_ra = b_idx;
         end
         ST_ADD_WB: begin
            edge_we = 1'b1; edge_wd = {a_idx, head_rd, w_ff};
            head_we = 1'b1; head_wa = b_idx; head_wd = ecount_ff;
            ecount_in = ecount_ff + 1'b1;
         end
         ST_INIT: begin
            node_we = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_START: begin
            // The start node enters the queue without its flag set.
            node_we = a_ok; node_wa = a_idx; node_wd = '0;
            q_we = a_ok; q_wa = '0; q_wd = a_idx;
            rd_in = '0; wr_in = (LAST_NODE == '0) ? '0 : NB'(1);
            cnt_in = a_ok ? (NB+1)'(1) : '0;
         end
         ST_POP: begin
            if (cnt_ff != '0) begin
               q_re = 1'b1;
               rd_in = rd_next;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_POP_W: begin
            t_in = q_rd;
            node_re = 1'b1; node_ra = q_rd;
            head_re = 1'b1; head_ra = q_rd;
         end
         ST_NODE: begin
            dist_t_in = node_rd[DIST_BITS-1:0];
            e_in = head_rd;
            node_we = 1'b1; node_wa = t_ff; node_wd = {1'b0, node_rd[DIST_BITS-1:0]};
         end
         ST_EDGE: edge_re = !(e_ff == NULL_LINK || e_ff >= ecount_ff);
         ST_EDGE_W: begin
            j_in = ej; e_in = enext; cand_in = cand_calc;
            node_re = 1'b1; node_ra = ej;
         end
         ST_RELAX: begin
            if (node_rd[DIST_BITS-1:0] > cand_ff) begin
               node_we = 1'b1; node_wa = j_ff;
               node_wd = {node_rd[DIST_BITS] | push, cand_ff};
               if (push) begin
                  q_we = 1'b1;
                  wr_in = wr_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_FINAL: begin
            node_re = b_ok; node_ra = b_idx;
         end
         ST_FINAL_W: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {d_final <= HALF_SENTINEL, d_final};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         node_count_ff <= NODE_COUNT_RESET;
         idx_ff <= '0;
         ecount_ff <= '0;
         cnt_ff <= '0;
         sweep_all_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_count_ff <= node_count_in;
         idx_ff <= idx_in;
         ecount_ff <= ecount_in;
         cnt_ff <= cnt_in;
         sweep_all_ff <= sweep_all_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; w_ff <= w_in;
      rd_ff <= rd_in; wr_ff <= wr_in; lim_ff <= lim_in;
      t_ff <= t_in; j_ff <= j_in; e_ff <= e_in;
      dist_t_ff <= dist_t_in; cand_ff <= cand_in;
      rsp_data_ff <= rsp_data_in;
   end

   spfa_ram #(.WIDTH(EB), .DEPTH(MAX_NODES)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_en(head_re), .rd_addr(head_ra), .rd_data(head_rd));

   // Each node entry holds its queue flag above its distance.
   spfa_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(node_rd));

   spfa_ram #(.WIDTH(EW), .DEPTH(MAX_EDGE_SLOTS)) u_edge (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_en(edge_re), .rd_addr(edge_ra), .rd_data(edge_rd));

   spfa_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_en(q_re), .rd_addr(q_ra), .rd_data(q_rd));
endmodule
`default_nettype wire

@@ sv/spfa_ram.sv @@
// Generic single write port RAM with one registered read port.
`default_nettype none
module spfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ tb/tb_spfa_shortest_path_unit.sv @@
// Self-checking testbench: shortest path unit against an SPFA distance predictor.
`default_nettype none
module tb_spfa_shortest_path_unit
   import spfa_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = DEF_MAX_NODES;
   localparam int SLOTS = DEF_MAX_EDGE_SLOTS;
   localparam int NO_LINK = -1;
   // A clear sweeps every head entry, so idle waits must outlast it.
   localparam int SETTLE_CYCLES = DEF_MAX_NODES + 100;

   typedef struct packed {
      logic                 reachable;
      logic [DIST_BITS-1:0] distance;
   } path_answer_type;

   class path_scoreboard_type;
      logic [COUNT_BITS-1:0]  node_count;
      logic [DIST_BITS-1:0]   node_dist [NODES];
      bit                     queued [NODES];
      int                     head [NODES];
      logic [NODE_BITS-1:0]   target [SLOTS];
      int                     next_link [SLOTS];
      logic [WEIGHT_IN_BITS-1:0] weight [SLOTS];
      int                     edge_count;
      path_answer_type        answers [$];
      int                     errors;

      function void clear_graph();
         foreach (head[i]) head[i] = NO_LINK;
         edge_count = 0;
      endfunction

      function void reset_state();
         node_count = NODE_COUNT_RESET;
         foreach (node_dist[i]) begin
            node_dist[i] = '0;
            queued[i] = 0;
         end
         clear_graph();
         answers.delete();
         errors = 0;
      endfunction

      function void link(int from, int to, logic [WEIGHT_IN_BITS-1:0] w);
         target[edge_count] = to[NODE_BITS-1:0];
         weight[edge_count] = w;
         next_link[edge_count] = head[from];
         head[from] = edge_count;
         edge_count++;
      endfunction

      // Queue-based relaxation; sums saturate at the sentinel.
      function void relax(int start);
         int work [$];
         int t;
         int e;
         int j;
         logic [31:0] cand;
         work.push_back(start);
         while (work.size() > 0) begin
            t = work.pop_front();
            queued[t] = 0;
            e = head[t];
            while (e != NO_LINK && e < edge_count) begin
               j = target[e];
               cand = {2'b00, node_dist[t]} + {16'd0, weight[e]};
               if (cand > {2'b00, SENTINEL}) cand = {2'b00, SENTINEL};
               if ({2'b00, node_dist[j]} > cand) begin
                  node_dist[j] = cand[DIST_BITS-1:0];
                  if (!queued[j] && work.size() < NODES) begin
                     work.push_back(j);
                     queued[j] = 1;
                  end
               end
               e = next_link[e];
            end
         end
      endfunction

      function void note_request(action_type act, int a, int b,
                                 logic [WEIGHT_IN_BITS-1:0] w);
         int n;
         path_answer_type ans;
         case (act)
            ACT_CLEAR: clear_graph();
            ACT_ADD: begin
               if (edge_count + 2 <= SLOTS) begin
                  link(a, b, w);
                  link(b, a, w);
               end
            end
            ACT_QUERY: begin
               n = (node_count > NODES) ? NODES : node_count;
               for (int i = 0; i < n; i++) begin
                  node_dist[i] = SENTINEL;
                  queued[i] = 0;
               end
               node_dist[a] = '0;
               relax(a);
               ans.distance = node_dist[b];
               ans.reachable = (node_dist[b] > HALF_SENTINEL) ? 1'b0 : 1'b1;
               answers.push_back(ans);
            end
            default: ;
         endcase
      endfunction

      function void check_answer(logic [RSP_BITS-1:0] data);
         path_answer_type exp_ans;
         if (answers.size() == 0) begin
            $error("result transfer with no query outstanding: %h", data);
            errors++;
            return;
         end
         exp_ans = answers.pop_front();
         if (data[0] !== exp_ans.reachable) begin
            $error("reachable: expected %0d, got %0d", exp_ans.reachable, data[0]);
            errors++;
         end
         if (data[DIST_BITS:1] !== exp_ans.distance) begin
            $error("distance: expected %0d, got %0d", exp_ans.distance,
                   data[DIST_BITS:1]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_BITS-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data = '0;

   path_scoreboard_type paths = new();
   bit quiet = 0;
   int base_node;
   int span;

   always #4 clock = ~clock;

   spfa_shortest_path_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   task automatic send(action_type act, int a, int b, int w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, w[WEIGHT_IN_BITS-1:0], b[NODE_BITS-1:0],
                    a[NODE_BITS-1:0], act};
      do @(posedge clock); while (!req_tready);
      paths.note_request(act, a, b, w[WEIGHT_IN_BITS-1:0]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (paths.answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(int value);
      csr_valid <= 1'b1;
      csr_data <= value[COUNT_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      paths.node_count = value[COUNT_BITS-1:0];
   endtask

   function automatic int pick_node();
      return base_node + $urandom_range(0, span);
   endfunction

   task automatic random_phase(int items);
      int sent;
      int k;
      sent = 0;
      while (sent < items) begin
         k = $urandom_range(0, 99);
         if (k < 2) begin
            send(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 65535));
            sent++;
         end else if (k < 6) begin
            // Noise: unused action or an edge between arbitrary nodes.
            if (k < 4) send(ACT_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 65535));
            else send(ACT_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 65535));
            sent++;
         end else begin
            repeat ($urandom_range(1, 10)) begin
               send(ACT_ADD, pick_node(), pick_node(),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 300));
               sent++;
            end
            repeat ($urandom_range(1, 4)) begin
               send(ACT_QUERY, pick_node(), pick_node(), $urandom_range(0, 65535));
               sent++;
            end
         end
      end
   endtask

   initial begin
      forever begin
         int stall;
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         paths.check_answer(rsp_tdata);
      end
   end

   initial begin
      #400ms;
      $display("tb_spfa_shortest_path_unit: errors");
      $finish;
   end

   initial begin
      int counts [8];
      paths.reset_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: full initialization comes first so every distance is written.
      send(ACT_QUERY, 0, 1023, 0);
      send(ACT_ADD, 0, 1023, 65535);
      send(ACT_ADD, 1023, 5, 0);
      send(ACT_ADD, 5, 5, 7);
      send(ACT_ADD, 0, 6, 1);
      send(ACT_ADD, 6, 1023, 2);
      send(ACT_QUERY, 0, 1023, 65535);
      send(ACT_QUERY, 1023, 5, 0);
      send(ACT_QUERY, 5, 5, 0);
      send(ACT_QUERY, 0, 700, 0);
      send(ACT_NONE, 1023, 1023, 65535);
      send(ACT_CLEAR, 0, 0, 0);
      send(ACT_QUERY, 0, 1023, 0);
      wait_idle();
      write_count(0);
      send(ACT_ADD, 2, 3, 9);
      send(ACT_QUERY, 2, 3, 0);
      send(ACT_QUERY, 3, 900, 0);
      wait_idle();
      write_count(1);
      send(ACT_QUERY, 3, 2, 0);
      send(ACT_QUERY, 0, 3, 0);
      wait_idle();
      write_count(2047);
      send(ACT_QUERY, 2, 3, 0);

      counts = '{1024, 2047, 1, 0, 1025, 16, 40, 64};
      for (int phase = 0; phase < 14; phase++) begin
         wait_idle();
         if (phase < 8) write_count(counts[phase]);
         else write_count($urandom_range(1, 64));
         quiet = (phase % 4 == 2);
         base_node = $urandom_range(0, 1008);
         if (phase == 5) base_node = 1008;
         span = $urandom_range(3, 15);
         send(ACT_CLEAR, 0, 0, 0);
         random_phase((counts[phase % 8] > 100 && phase < 8) ? 40 : 150);
      end

      req_tvalid <= 1'b0;
      while (paths.answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (paths.errors == 0)
         $display("tb_spfa_shortest_path_unit: clean");
      else
         $display("tb_spfa_shortest_path_unit: errors");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
sv/spfa_pkg.sv
sv/spfa_ram.sv
sv/spfa_shortest_path_unit.sv
tb/tb_spfa_shortest_path_unit.sv
